>>> rtl/core/ees_pkg.sv
// shared types and constants of the estimate error statistics block
package ees_pkg;
  localparam int unsigned COUNT_WIDTH_DEFAULT = 32;
  // fraction bits of the Q16.16 data; the exact integer arithmetic does not depend on it
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned SUM_WIDTH  = 48;
  localparam int unsigned SQ_WIDTH   = 64;
  localparam int unsigned WIDE_WIDTH = 128;

  localparam logic CMD_LOG  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] CH_OFFSET   = 2'd0;
  localparam logic [1:0] CH_SPEED    = 2'd1;
  localparam logic [1:0] CH_ACCEL    = 2'd2;
  localparam logic [1:0] CH_RESIDUAL = 2'd3;

  // shared 32x32 multiplier request
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;
endpackage

>>> rtl/core/ees_mul.sv
// registered 32x32 unsigned multiplier shared by all sequencer steps
module ees_mul (
  input  logic           clk,
  input  ees_pkg::mul_req_t req,
  output logic [63:0]    product
);
  import ees_pkg::*;

  always_ff @(posedge clk) begin
    product <= 64'(req.a) * 64'(req.b);
  end
endmodule

>>> rtl/core/estimate_error_statistics_unit.sv
// top level of the estimate error statistics block
// Accumulates the errors of a state estimator and answers a read of one channel
// with its count, mean and sample standard deviation (no deviation for the
// residual channel). Requests are taken one at a time: in_stall is high from
// acceptance until the result is taken, and the next request can be accepted the
// cycle after that. A log request goes through each used component in turn (the
// shared 32x32 multiplier squares the error, then the accumulators update); a
// rejected log or a read of an empty channel goes straight to its result.
// A read builds n*S2, S*S and n*(n-1) from 32x32 partial products on the same
// multiplier, then performs the mean division (restoring, one quotient bit per
// cycle); when the deviation is given, the variance division and the square root
// (one result bit per cycle) follow. Values are signed Q16.16; the arithmetic is
// exact integer and the fraction position is carried by the data.
module estimate_error_statistics_unit #(
  parameter int unsigned COUNT_WIDTH = ees_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [2:0]         actual_count,
  input  logic [2:0]         estimate_count,
  input  logic signed [31:0] actual_offset,
  input  logic signed [31:0] actual_speed,
  input  logic signed [31:0] actual_accel,
  input  logic signed [31:0] est_offset,
  input  logic signed [31:0] est_speed,
  input  logic signed [31:0] est_accel,
  input  logic signed [31:0] residual,
  input  logic [1:0]         channel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic               channel_empty,
  output logic [31:0]        sample_count,
  output logic signed [31:0] mean_value,
  output logic [31:0]        std_deviation,
  output logic               deviation_valid
);
  import ees_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_LSQ, S_LACC, S_RMUL, S_RACC, S_MDIV, S_VDIV, S_SQRT, S_OUT
  } state_t;

  state_t state;

  logic [COUNT_WIDTH-1:0]     counts [4];
  logic signed [SUM_WIDTH-1:0] sums  [4];
  logic [SQ_WIDTH-1:0]        sqs   [3];

  logic signed [32:0] deltas [3];
  logic [1:0]  idx;
  logic [1:0]  ncomp;
  logic signed [31:0] res_q;
  logic [1:0]  ch_q;

  // multiplier sequencing
  mul_req_t    mreq;
  logic [63:0] mprod;
  logic [3:0]  step;
  logic [127:0] acc_a, acc_b, acc_c;
  logic [63:0] op_n, op_s2, op_s, op_nm1;
  logic [63:0] src_x, src_y;

  ees_mul u_mul (.clk(clk), .req(mreq), .product(mprod));

  // divider and root
  logic [127:0] dnum, dquo, drem, dden;
  logic [7:0]   dcnt;
  logic [63:0]  root;
  logic [127:0] radicand;
  logic [6:0]   rcnt;
  logic         mean_neg;

  logic [128:0] rem_shift;
  logic [63:0]  cand;

  always_comb begin
    rem_shift = {drem, dnum[127]};
    cand = root | (64'd1 << rcnt[5:0]);
    src_x = '0;
    src_y = '0;
    mreq.a = '0;
    mreq.b = '0;
    unique case (state)
      S_LSQ: begin
        mreq.a = deltas[idx][32] ? 32'(-deltas[idx]) : deltas[idx][31:0];
        mreq.b = mreq.a;
      end
      S_RMUL: begin
        // steps 0..3: n*S2 partials, 4..7: S*S partials, 8..11: n*(n-1) partials
        src_x = (step[3] || !step[2]) ? op_n : op_s;
        src_y = step[3] ? op_nm1 : (step[2] ? op_s : op_s2);
        mreq.a = step[1] ? src_x[63:32] : src_x[31:0];
        mreq.b = step[0] ? src_y[63:32] : src_y[31:0];
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  // square compare for root, done as a 128-bit test of candidate^2 built from the running square
  logic [127:0] cand_sq;
  logic [127:0] root_sq;   // running square of root
  logic [127:0] trial;
  always_comb begin
    // (r + 2^i)^2 = r^2 + r*2^(i+1) + 2^(2i)
    trial = root_sq + ({64'd0, root} << (rcnt[5:0] + 7'd1))
          + (128'd1 << {rcnt[5:0], 1'b0});
    cand_sq = trial;
  end

  logic signed [SUM_WIDTH:0] sum_ext;
  logic signed [SUM_WIDTH:0] res_ext;
  logic [SQ_WIDTH:0] sq_ext;
  logic [127:0] pp_shifted;
  always_comb begin
    unique case (step[1:0])
      2'd0: pp_shifted = {64'd0, mprod};
      2'd1, 2'd2: pp_shifted = {32'd0, mprod, 32'd0};
      default: pp_shifted = {mprod, 64'd0};
    endcase
    sum_ext = (SUM_WIDTH+1)'(sums[idx]) + (SUM_WIDTH+1)'(deltas[idx]);
    res_ext = (SUM_WIDTH+1)'(sums[3]) + (SUM_WIDTH+1)'(res_q);
    sq_ext = (SQ_WIDTH+1)'(sqs[idx]) + (SQ_WIDTH+1)'(mprod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        counts[i] <= '0;
        sums[i] <= '0;
      end
      for (int i = 0; i < 3; i++) sqs[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            accepted <= 1'b0;
            channel_empty <= (command == CMD_READ) && (counts[channel] == '0);
            sample_count <= (command == CMD_LOG) ? '0
                          : (64'(counts[channel]) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                          : 32'(counts[channel]);
            mean_value <= '0;
            std_deviation <= '0;
            deviation_valid <= 1'b0;
            deltas[0] <= 33'(est_offset) - 33'(actual_offset);
            deltas[1] <= 33'(est_speed) - 33'(actual_speed);
            deltas[2] <= 33'(est_accel) - 33'(actual_accel);
            res_q <= residual;
            ch_q <= channel;
            idx <= '0;
            step <= '0;
            if (command == CMD_LOG) begin
              if ((actual_count == 3'd2 || actual_count == 3'd3)
                  && estimate_count == actual_count) begin
                ncomp <= actual_count[1:0];
                state <= S_LSQ;
              end else begin
                state <= S_OUT;
                out_valid <= 1'b1;
              end
            end else begin
              op_n <= 64'(counts[channel]);
              op_nm1 <= 64'(counts[channel]) - 64'd1;
              op_s2 <= (channel == CH_RESIDUAL) ? 64'd0
                     : sqs[channel[1] ? 2'd2 : {1'b0, channel[0]}];
              op_s <= sums[channel][SUM_WIDTH-1] ? -64'(sums[channel])
                    : 64'(sums[channel]);
              mean_neg <= sums[channel][SUM_WIDTH-1];
              if (counts[channel] == '0) begin
                state <= S_OUT;
                out_valid <= 1'b1;
              end else begin
                acc_a <= '0;
                acc_b <= '0;
                acc_c <= '0;
                state <= S_RMUL;
              end
            end
          end
        end
        S_LSQ: begin
          // wait for the registered product, then accumulate in S_LACC
          state <= S_LACC;
        end
        S_LACC: begin
          if (counts[idx] != COUNT_MAX) counts[idx] <= counts[idx] + 1'b1;
          if (sum_ext > (SUM_WIDTH+1)'(SUM_MAX)) sums[idx] <= SUM_MAX;
          else if (sum_ext < (SUM_WIDTH+1)'(SUM_MIN)) sums[idx] <= SUM_MIN;
          else sums[idx] <= SUM_WIDTH'(sum_ext);
          sqs[idx] <= sq_ext[SQ_WIDTH] ? '1 : sq_ext[SQ_WIDTH-1:0];
          if (idx == ncomp - 2'd1) begin
            if (counts[3] != COUNT_MAX) counts[3] <= counts[3] + 1'b1;
            if (res_ext > (SUM_WIDTH+1)'(SUM_MAX)) sums[3] <= SUM_MAX;
            else if (res_ext < (SUM_WIDTH+1)'(SUM_MIN)) sums[3] <= SUM_MIN;
            else sums[3] <= SUM_WIDTH'(res_ext);
            accepted <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            idx <= idx + 2'd1;
            state <= S_LSQ;
          end
        end
        S_RMUL: begin
          state <= S_RACC;
        end
        S_RACC: begin
          if (step[3]) acc_c <= acc_c + pp_shifted;
          else if (step[2]) acc_b <= acc_b + pp_shifted;
          else acc_a <= acc_a + pp_shifted;
          if (step == 4'd11) begin
            // mean division first: |S| / n
            dnum <= {64'd0, op_s};
            dden <= {64'd0, op_n};
            drem <= '0;
            dquo <= '0;
            dcnt <= 8'd127;
            state <= S_MDIV;
          end else begin
            step <= step + 4'd1;
            state <= S_RMUL;
          end
        end
        S_MDIV, S_VDIV: begin
          if (dcnt != 8'd0) begin
            if (rem_shift >= {1'b0, dden}) begin
              drem <= 128'(rem_shift - {1'b0, dden});
              dquo <= {dquo[126:0], 1'b1};
            end else begin
              drem <= rem_shift[127:0];
              dquo <= {dquo[126:0], 1'b0};
            end
            dnum <= {dnum[126:0], 1'b0};
            dcnt <= dcnt - 8'd1;
          end else if (state == S_MDIV) begin
            if (mean_neg)
              mean_value <= ({dquo[126:0], 1'b0} != '0 || rem_shift >= {1'b0, dden})
                ? ((({dquo[126:0], rem_shift >= {1'b0, dden}}) > 128'h8000_0000)
                   ? 32'sh8000_0000
                   : 32'(-({dquo[126:0], rem_shift >= {1'b0, dden}})))
                : '0;
            else
              mean_value <= (({dquo[126:0], rem_shift >= {1'b0, dden}}) > 128'h7FFF_FFFF)
                ? 32'sh7FFF_FFFF : 32'({dquo[126:0], rem_shift >= {1'b0, dden}});
            if (ch_q != CH_RESIDUAL && op_n >= 64'd2) begin
              deviation_valid <= 1'b1;
              if (acc_a >= acc_b) begin
                dnum <= acc_a - acc_b;
                dden <= acc_c;
                drem <= '0;
                dquo <= '0;
                dcnt <= 8'd127;
                state <= S_VDIV;
              end else begin
                std_deviation <= '0;
                out_valid <= 1'b1;
                state <= S_OUT;
              end
            end else begin
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            radicand <= {dquo[126:0], rem_shift >= {1'b0, dden}};
            root <= '0;
            root_sq <= '0;
            rcnt <= 7'd63;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cand_sq <= radicand) begin
            root <= cand;
            root_sq <= cand_sq;
          end
          rcnt <= rcnt - 7'd1;
          if (rcnt == 7'd0) begin
            std_deviation <= (((cand_sq <= radicand) ? cand : root) > 64'hFFFF_FFFF)
              ? 32'hFFFF_FFFF : 32'((cand_sq <= radicand) ? cand : root);
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
endmodule

>>> rtl/core/ees_checker.sv
// port-level checks of the estimate error statistics block, bound to the top level
module ees_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        accepted,
  input logic        channel_empty,
  input logic        deviation_valid,
  input logic [31:0] std_deviation
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("accepted request did not stall");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result shown while idle");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && (channel_empty || deviation_valid)))
    else $error("log and read flags mixed");
  a_dev: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !deviation_valid) |-> std_deviation == 32'd0)
    else $error("deviation without valid");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("stalled result dropped");
endmodule

bind estimate_error_statistics_unit ees_checker u_ees_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .accepted(accepted),
  .channel_empty(channel_empty), .deviation_valid(deviation_valid),
  .std_deviation(std_deviation)
);
